### rtl/stscan_pkg.sv
package stscan_pkg;

    localparam int PosW  = 32;
    localparam int LineW = 24;
    localparam int ColW  = 16;
    localparam int LenW  = 16;

    // token kinds
    localparam logic [5:0] K_INT    = 6'd0;
    localparam logic [5:0] K_STR    = 6'd1;
    localparam logic [5:0] K_CHR    = 6'd2;
    localparam logic [5:0] K_IDENT  = 6'd3;
    localparam logic [5:0] K_PLUS   = 6'd4;
    localparam logic [5:0] K_MINUS  = 6'd5;
    localparam logic [5:0] K_STAR   = 6'd6;
    localparam logic [5:0] K_DIV    = 6'd7;
    localparam logic [5:0] K_MOD    = 6'd8;
    localparam logic [5:0] K_ASSIGN = 6'd9;
    localparam logic [5:0] K_LT     = 6'd10;
    localparam logic [5:0] K_GT     = 6'd11;
    localparam logic [5:0] K_LE     = 6'd12;
    localparam logic [5:0] K_GE     = 6'd13;
    localparam logic [5:0] K_EQ     = 6'd14;
    localparam logic [5:0] K_NE     = 6'd15;
    localparam logic [5:0] K_ANDAND = 6'd16;
    localparam logic [5:0] K_OROR   = 6'd17;
    localparam logic [5:0] K_NOT    = 6'd18;
    localparam logic [5:0] K_FN     = 6'd19;
    localparam logic [5:0] K_STRUCT = 6'd20;
    localparam logic [5:0] K_IF     = 6'd21;
    localparam logic [5:0] K_ELSE   = 6'd22;
    localparam logic [5:0] K_WHILE  = 6'd23;
    localparam logic [5:0] K_RETURN = 6'd24;
    localparam logic [5:0] K_LET    = 6'd25;
    localparam logic [5:0] K_TRUE   = 6'd26;
    localparam logic [5:0] K_FALSE  = 6'd27;
    localparam logic [5:0] K_LPAREN = 6'd28;
    localparam logic [5:0] K_RPAREN = 6'd29;
    localparam logic [5:0] K_LBRACE = 6'd30;
    localparam logic [5:0] K_RBRACE = 6'd31;
    localparam logic [5:0] K_LBRACK = 6'd32;
    localparam logic [5:0] K_RBRACK = 6'd33;
    localparam logic [5:0] K_COLON  = 6'd34;
    localparam logic [5:0] K_SEMI   = 6'd35;
    localparam logic [5:0] K_COMMA  = 6'd36;
    localparam logic [5:0] K_DOT    = 6'd37;
    localparam logic [5:0] K_END    = 6'd38;

    // error codes
    localparam logic [3:0] E_NONE      = 4'd0;
    localparam logic [3:0] E_INT_SUFX  = 4'd1;
    localparam logic [3:0] E_CHR_UNTRM = 4'd2;
    localparam logic [3:0] E_CHR_MULTI = 4'd3;
    localparam logic [3:0] E_STR_UNTRM = 4'd4;
    localparam logic [3:0] E_STR_EMPTY = 4'd5;
    localparam logic [3:0] E_AMP       = 4'd6;
    localparam logic [3:0] E_BAR       = 4'd7;
    localparam logic [3:0] E_UNSUP     = 4'd8;

    typedef struct packed {
        logic [5:0]       token_kind;
        logic [3:0]       error_code;
        logic [PosW-1:0]  start_pos;
        logic [LenW-1:0]  token_size;
        logic [LineW-1:0] line_no;
        logic [ColW-1:0]  column_no;
        logic [31:0]      int_value;
        logic [7:0]       char_value;
        logic             last_of_run;
    } t_res;

    typedef struct packed {
        logic v0;
        logic v1;
        t_res r0;
        t_res r1;
    } t_push;

    function automatic t_res mk_res(input logic [5:0] kind, input logic [3:0] err,
                                    input logic [PosW-1:0] pos, input logic [LenW-1:0] size,
                                    input logic [LineW-1:0] line, input logic [ColW-1:0] col,
                                    input logic [31:0] ival, input logic [7:0] cval);
        t_res r;
        r.token_kind  = kind;
        r.error_code  = err;
        r.start_pos   = pos;
        r.token_size  = size;
        r.line_no     = line;
        r.column_no   = col;
        r.int_value   = ival;
        r.char_value  = cval;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // keyword lookup on the letter prefix, 0 when none
    function automatic logic [5:0] kw_kind(input logic [LenW-1:0] len, input logic [47:0] pref);
        logic [5:0] k;
        k = K_INT;
        if (len == 16'd2 && pref == 48'h666E)         k = K_FN;
        if (len == 16'd6 && pref == 48'h737472756374) k = K_STRUCT;
        if (len == 16'd2 && pref == 48'h6966)         k = K_IF;
        if (len == 16'd4 && pref == 48'h656C7365)     k = K_ELSE;
        if (len == 16'd5 && pref == 48'h7768696C65)   k = K_WHILE;
        if (len == 16'd6 && pref == 48'h72657475726E) k = K_RETURN;
        if (len == 16'd3 && pref == 48'h6C6574)       k = K_LET;
        if (len == 16'd4 && pref == 48'h74727565)     k = K_TRUE;
        if (len == 16'd5 && pref == 48'h66616C7365)   k = K_FALSE;
        return k;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h25:   k = K_MOD;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h3A:   k = K_COLON;
            8'h3B:   k = K_SEMI;
            8'h2C:   k = K_COMMA;
            8'h2E:   k = K_DOT;
            default: k = K_INT;
        endcase
        return k;
    endfunction

endpackage

### rtl/stscan_byte_if.sv
interface stscan_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink (input valid, input source_byte, output ready);
endinterface

### rtl/stscan_tok_if.sv
interface stscan_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [3:0]  error_code;
    logic [31:0] start_pos;
    logic [15:0] token_size;
    logic [23:0] line_no;
    logic [15:0] column_no;
    logic [31:0] int_value;
    logic [7:0]  char_value;
    logic        last_of_run;

    modport source (output valid, output token_kind, output error_code, output start_pos,
                    output token_size, output line_no, output column_no, output int_value,
                    output char_value, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input error_code, input start_pos,
                  input token_size, input line_no, input column_no, input int_value,
                  input char_value, input last_of_run, output ready);
endinterface

### rtl/stscan_front.sv
module stscan_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    output stscan_pkg::t_push  o_push
);
    import stscan_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INT, S_WORD, S_STR, S_CHR, S_SLASH, S_LINE, S_BLOCK, S_HASH,
        S_EQ, S_LT, S_GT, S_BANG, S_AMP, S_BAR
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [PosW-1:0]  r_pos, n_pos, r_tstart, n_tstart;
    logic [LineW-1:0] r_line, n_line;
    logic [ColW-1:0]  r_col, n_col, r_tcol, n_tcol;
    logic [LenW-1:0]  r_tlen, n_tlen;
    logic [31:0]      r_acc, n_acc;
    logic [47:0]      r_pref, n_pref;
    logic             r_still, n_still, r_halt, n_halt;
    logic [7:0]       r_lchar, n_lchar;

    logic       is_dig, is_let, is_idn, is_vis, is_spc, do_idle, kdone;
    logic       v0, v1;
    t_res       e0, e1;
    logic [5:0] k;
    logic [16:0] slen;

    assign is_dig = i_byte >= "0" && i_byte <= "9";
    assign is_let = (i_byte >= "a" && i_byte <= "z") || (i_byte >= "A" && i_byte <= "Z");
    assign is_idn = is_let || i_byte == "_";
    assign is_vis = i_byte >= 8'd33 && i_byte <= 8'd126;
    assign is_spc = i_byte == 8'h0A || i_byte == 8'h0D || i_byte == 8'h09 || i_byte == " ";

    always_comb begin
        n_mode = r_mode; n_pos = r_pos; n_line = r_line; n_col = r_col;
        n_tstart = r_tstart; n_tcol = r_tcol; n_tlen = r_tlen; n_acc = r_acc;
        n_pref = r_pref; n_still = r_still; n_halt = r_halt; n_lchar = r_lchar;
        v0 = 1'b0; v1 = 1'b0; e0 = '0; e1 = '0;
        do_idle = 1'b0; kdone = 1'b0; k = K_INT;
        slen = {1'b0, r_tlen} + 17'd1;

        if (r_halt) begin
            if (i_byte == 8'd0) begin
                n_mode = S_IDLE; n_pos = '0; n_line = '0; n_col = '0; n_halt = 1'b0;
            end
        end else begin
            // mode part: closes or extends the token in progress
            unique case (r_mode)
                S_INT: begin
                    if (is_dig) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + {24'd0, i_byte - 8'h30};
                        if (r_tlen != '1) n_tlen = r_tlen + 16'd1;
                        n_col = r_col + 16'd1;
                    end else if (is_idn) begin
                        v0 = 1'b1;
                        e0 = mk_res(K_INT, E_INT_SUFX, r_pos, '0, r_line, r_tcol, '0, '0);
                        n_halt = 1'b1; n_mode = S_IDLE;
                    end else begin
                        v0 = 1'b1;
                        e0 = mk_res(K_INT, E_NONE, r_tstart, r_tlen, r_line, r_tcol, r_acc, '0);
                        do_idle = 1'b1;
                    end
                end
                S_WORD: begin
                    if (r_still && is_let) begin
                        n_pref = {r_pref[39:0], i_byte};
                        if (r_tlen != '1) n_tlen = r_tlen + 16'd1;
                        n_col = r_col + 16'd1;
                    end else begin
                        if (r_still) begin
                            n_still = 1'b0;
                            k = kw_kind(r_tlen, r_pref);
                            if (k != K_INT) begin
                                v0 = 1'b1;
                                e0 = mk_res(k, E_NONE, r_tstart, r_tlen, r_line, r_tcol,
                                            '0, '0);
                                do_idle = 1'b1; kdone = 1'b1;
                            end
                        end
                        if (!kdone) begin
                            if (is_idn || is_dig) begin
                                if (r_tlen != '1) n_tlen = r_tlen + 16'd1;
                                n_col = r_col + 16'd1;
                            end else begin
                                v0 = 1'b1;
                                e0 = mk_res(K_IDENT, E_NONE, r_tstart, r_tlen, r_line,
                                            r_tcol, '0, '0);
                                do_idle = 1'b1;
                            end
                        end
                    end
                end
                S_STR: begin
                    if (i_byte == 8'h22) begin
                        v0 = 1'b1;
                        n_mode = S_IDLE;
                        if (r_tlen == 16'd1) begin
                            n_col = r_col + 16'd1;
                            e0 = mk_res(K_INT, E_STR_EMPTY, r_tstart + 32'd1, '0, r_line,
                                        r_tcol, '0, '0);
                            n_halt = 1'b1;
                        end else begin
                            n_col = r_col + 16'd3;
                            e0 = mk_res(K_STR, E_NONE, r_tstart,
                                        slen[16] ? 16'hFFFF : slen[15:0], r_line, r_tcol,
                                        '0, '0);
                        end
                    end else if (is_vis || is_spc) begin
                        if (r_tlen != '1) n_tlen = r_tlen + 16'd1;
                        n_col = r_col + 16'd1;
                    end else begin
                        v0 = 1'b1;
                        e0 = mk_res(K_INT, E_STR_UNTRM, r_tstart, '0, r_line, r_tcol, '0, '0);
                        n_halt = 1'b1; n_mode = S_IDLE;
                    end
                end
                S_CHR: begin
                    if (i_byte == 8'h27) begin
                        v0 = 1'b1;
                        n_col = r_col + 16'd1;
                        e0 = mk_res(K_CHR, E_NONE, r_tstart, r_tlen + 16'd1, r_line, r_tcol,
                                    '0, r_tlen == 16'd1 ? 8'h27 : r_lchar);
                        n_mode = S_IDLE;
                    end else if (is_vis) begin
                        n_col = r_col + 16'd1;
                        if (r_tlen != '1) n_tlen = r_tlen + 16'd1;
                        if (n_tlen == 16'd2) n_lchar = i_byte;
                        if (n_tlen > 16'd2) begin
                            v0 = 1'b1;
                            e0 = mk_res(K_INT, E_CHR_MULTI, r_tstart, '0, r_line, r_tcol,
                                        '0, '0);
                            n_halt = 1'b1; n_mode = S_IDLE;
                        end
                    end else begin
                        v0 = 1'b1;
                        e0 = mk_res(K_INT, E_CHR_UNTRM, r_tstart, '0, r_line, r_tcol, '0, '0);
                        n_halt = 1'b1; n_mode = S_IDLE;
                    end
                end
                S_SLASH: begin
                    if (i_byte == "/") begin
                        n_mode = S_LINE;
                    end else if (i_byte == "#") begin
                        n_col = r_col + 16'd1; n_mode = S_BLOCK;
                    end else begin
                        v0 = 1'b1;
                        e0 = mk_res(K_DIV, E_NONE, r_tstart + 32'd1, 16'd1, r_line, r_tcol,
                                    '0, '0);
                        n_col = r_col + 16'd1;
                        do_idle = 1'b1;
                    end
                end
                S_LINE: begin
                    if (i_byte == 8'h0A || i_byte == 8'd0) do_idle = 1'b1;
                end
                S_BLOCK: begin
                    if (i_byte == 8'd0) begin
                        do_idle = 1'b1;
                    end else if (i_byte == 8'h0A) begin
                        n_line = r_line + 24'd1; n_col = 16'd1;
                    end else begin
                        n_col = r_col + 16'd1;
                        if (i_byte == "#") n_mode = S_HASH;
                    end
                end
                S_HASH: begin
                    if (i_byte == 8'd0) begin
                        do_idle = 1'b1;
                    end else begin
                        n_col = r_col + 16'd1;
                        n_mode = i_byte == "/" ? S_IDLE : S_BLOCK;
                    end
                end
                S_EQ, S_LT, S_GT, S_BANG: begin
                    v0 = 1'b1;
                    if (i_byte == "=") begin
                        k = r_mode == S_EQ ? K_EQ : r_mode == S_LT ? K_LE :
                            r_mode == S_GT ? K_GE : K_NE;
                        n_col = r_col + 16'd1;
                        e0 = mk_res(k, E_NONE, r_tstart, 16'd2, r_line, r_tcol, '0, '0);
                        n_mode = S_IDLE;
                    end else begin
                        k = r_mode == S_EQ ? K_ASSIGN : r_mode == S_LT ? K_LT :
                            r_mode == S_GT ? K_GT : K_NOT;
                        e0 = mk_res(k, E_NONE, r_tstart, 16'd1, r_line, r_tcol, '0, '0);
                        do_idle = 1'b1;
                    end
                end
                S_AMP, S_BAR: begin
                    v0 = 1'b1;
                    if (i_byte == (r_mode == S_AMP ? 8'h26 : 8'h7C)) begin
                        n_col = r_col + 16'd1;
                        e0 = mk_res(r_mode == S_AMP ? K_ANDAND : K_OROR, E_NONE, r_tstart,
                                    16'd2, r_line, r_tcol, '0, '0);
                    end else begin
                        e0 = mk_res(K_INT, r_mode == S_AMP ? E_AMP : E_BAR, r_tstart, '0,
                                    r_line, r_tcol, '0, '0);
                        n_halt = 1'b1;
                    end
                    n_mode = S_IDLE;
                end
                default: do_idle = 1'b1;
            endcase

            // between-token part: starts a new token from this byte
            if (do_idle) begin
                k = single_kind(i_byte);
                n_mode = S_IDLE;
                if (is_dig || is_idn || i_byte == 8'h22 || i_byte == 8'h27 || i_byte == "/"
                    || i_byte == "=" || i_byte == "<" || i_byte == ">" || i_byte == "!"
                    || i_byte == "&" || i_byte == "|") begin
                    n_tstart = r_pos; n_tcol = n_col; n_tlen = 16'd1;
                end
                if (is_dig) begin
                    n_mode = S_INT; n_acc = {24'd0, i_byte - 8'h30}; n_col = n_col + 16'd1;
                end else if (is_idn) begin
                    n_mode = S_WORD; n_still = is_let;
                    n_pref = is_let ? {40'd0, i_byte} : '0;
                    n_col = n_col + 16'd1;
                end else if (i_byte == 8'h22) begin
                    n_mode = S_STR; n_col = n_col + 16'd1;
                end else if (i_byte == 8'h27) begin
                    n_mode = S_CHR; n_lchar = '0; n_col = n_col + 16'd1;
                end else if (k != K_INT) begin
                    v1 = 1'b1;
                    e1 = mk_res(k, E_NONE, r_pos, 16'd1, n_line, n_col, '0, '0);
                    n_col = n_col + 16'd1;
                end else if (i_byte == "/") begin
                    n_mode = S_SLASH;
                end else if (i_byte == "=" || i_byte == "<" || i_byte == ">" || i_byte == "!"
                             || i_byte == "&" || i_byte == "|") begin
                    n_mode = i_byte == "=" ? S_EQ : i_byte == "<" ? S_LT :
                             i_byte == ">" ? S_GT : i_byte == "!" ? S_BANG :
                             i_byte == "&" ? S_AMP : S_BAR;
                    n_col = n_col + 16'd1;
                end else if (i_byte == 8'd0) begin
                    v1 = 1'b1;
                    e1 = mk_res(K_END, E_NONE, r_pos, 16'd1, n_line, n_col, '0, '0);
                    n_col = n_col + 16'd1;
                end else if (i_byte == 8'h0A) begin
                    n_line = n_line + 24'd1; n_col = '0;
                end else if (i_byte == " ") begin
                    n_col = n_col + 16'd1;
                end else begin
                    n_tcol = n_col;
                    v1 = 1'b1;
                    e1 = mk_res(K_INT, E_UNSUP, r_pos, '0, n_line, n_col, '0, '0);
                    n_halt = 1'b1;
                end
            end

            if (i_byte == 8'd0) begin
                n_mode = S_IDLE; n_pos = '0; n_line = '0; n_col = '0; n_halt = 1'b0;
            end else begin
                n_pos = r_pos + 32'd1;
            end
        end

        e0.last_of_run = v0 && !v1;
        e1.last_of_run = v1;
    end

    assign o_push.v0 = i_accept && v0;
    assign o_push.v1 = i_accept && v1;
    assign o_push.r0 = e0;
    assign o_push.r1 = e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE; r_pos <= '0; r_line <= '0; r_col <= '0;
            r_tstart <= '0; r_tcol <= '0; r_tlen <= '0; r_acc <= '0;
            r_pref <= '0; r_still <= 1'b0; r_lchar <= '0; r_halt <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode; r_pos <= n_pos; r_line <= n_line; r_col <= n_col;
            r_tstart <= n_tstart; r_tcol <= n_tcol; r_tlen <= n_tlen; r_acc <= n_acc;
            r_pref <= n_pref; r_still <= n_still; r_lchar <= n_lchar; r_halt <= n_halt;
        end
    end
endmodule

### rtl/stscan_queue.sv
module stscan_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stscan_pkg::t_push i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output stscan_pkg::t_res  o_res
);
    import stscan_pkg::*;

    t_res       r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       pop;
    t_res       first;
    logic [2:0] npush;

    assign first   = i_push.v0 ? i_push.r0 : i_push.r1;
    assign npush   = {2'd0, i_push.v0} + {2'd0, i_push.v1};
    assign o_valid = r_cnt != 3'd0;
    assign o_res   = r_q[r_rp];
    assign pop     = o_valid && i_ready;
    // two free slots so that a byte giving two transfers never stalls mid-way
    assign o_room  = r_cnt <= 3'd2;

    always_ff @(posedge i_clk) begin
        if (npush != 3'd0) r_q[r_wp] <= first;
        if (npush == 3'd2) r_q[r_wp + 2'd1] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + npush[1:0];
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + npush - {2'd0, pop};
        end
    end
endmodule

### rtl/source_token_scanner.sv
// source token scanner: takes one source byte per cycle on i_src and gives tokens
// and error reports on o_tok, up to two transfers per byte (last_of_run marks the
// final one). the front scanner holds the token state machine and classifies each
// byte combinationally; its results go into a four-entry queue that feeds o_tok.
// i_src.ready drops only while the queue has fewer than two free slots, so the
// sustained rate is one byte per cycle whenever o_tok takes one transfer per cycle;
// a run of bytes that each give two results is limited by the single output port.
// after an error report the scanner drops input until byte 0, which restarts
// position, line and column at zero
module source_token_scanner (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stscan_byte_if.sink   i_src,
    stscan_tok_if.source  o_tok
);
    import stscan_pkg::*;

    t_push push;
    t_res  res;
    logic  room;
    logic  accept;

    // a byte transfer completes when the queue has room for both possible results
    assign i_src.ready = room;
    assign accept      = i_src.valid && room;

    stscan_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_src.source_byte),
        .o_push   (push)
    );

    // back end: queue decouples the scanner from output stalls
    stscan_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_tok.valid),
        .i_ready (o_tok.ready),
        .o_res   (res)
    );

    assign o_tok.token_kind  = res.token_kind;
    assign o_tok.error_code  = res.error_code;
    assign o_tok.start_pos   = res.start_pos;
    assign o_tok.token_size  = res.token_size;
    assign o_tok.line_no     = res.line_no;
    assign o_tok.column_no   = res.column_no;
    assign o_tok.int_value   = res.int_value;
    assign o_tok.char_value  = res.char_value;
    assign o_tok.last_of_run = res.last_of_run;
endmodule

### tb/testbench.sv
module testbench;
    import stscan_pkg::*;

    localparam int StallLimit = 4000;

    // scanner modes of the predictor
    typedef enum logic [3:0] {
        S_IDLE, S_INT, S_WORD, S_STR, S_CHR, S_SLASH, S_LINE, S_BLOCK, S_HASH,
        S_EQ, S_LT, S_GT, S_BANG, S_AMP, S_BAR
    } t_mode;

    logic i_clk;
    logic i_rst_n;

    stscan_byte_if src_if ();
    stscan_tok_if  tok_if ();

    source_token_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if),
        .o_tok   (tok_if)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // predictor state
    t_mode       mode;
    logic [31:0] pos_q;
    logic [23:0] line_q;
    logic [15:0] col_q;
    logic [31:0] tstart;
    logic [15:0] tcol;
    logic [15:0] tlen;
    logic [31:0] num_q;
    logic [47:0] prefix_q;
    logic        letters_q;
    logic [7:0]  chr_q;
    logic        halted;

    t_res expected_tokens[$];
    t_res step_out[$];
    int   mismatches;
    int   idle_cycles;
    logic accepting;
    logic rx_random_stall;

    function automatic logic is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_let(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_idc(logic [7:0] b);
        return is_let(b) || b == "_";
    endfunction

    function automatic logic is_vis(logic [7:0] b);
        return b >= 8'd33 && b <= 8'd126;
    endfunction

    function automatic logic [5:0] op_kind(logic [7:0] b);
        case (b)
            "+": return K_PLUS;
            "-": return K_MINUS;
            "*": return K_STAR;
            "%": return K_MOD;
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            "[": return K_LBRACK;
            "]": return K_RBRACK;
            ":": return K_COLON;
            ";": return K_SEMI;
            ",": return K_COMMA;
            ".": return K_DOT;
            default: return K_INT;
        endcase
    endfunction

    function automatic logic [5:0] keyword_of(logic [15:0] len, logic [47:0] p);
        if (len == 2 && p == 48'h666E) return K_FN;
        if (len == 6 && p == 48'h737472756374) return K_STRUCT;
        if (len == 2 && p == 48'h6966) return K_IF;
        if (len == 4 && p == 48'h656C7365) return K_ELSE;
        if (len == 5 && p == 48'h7768696C65) return K_WHILE;
        if (len == 6 && p == 48'h72657475726E) return K_RETURN;
        if (len == 3 && p == 48'h6C6574) return K_LET;
        if (len == 4 && p == 48'h74727565) return K_TRUE;
        if (len == 5 && p == 48'h66616C7365) return K_FALSE;
        return K_INT;
    endfunction

    task automatic push_token(logic [5:0] k, logic [3:0] e, logic [31:0] p,
                              logic [15:0] sz, logic [15:0] c, logic [31:0] iv,
                              logic [7:0] cv);
        t_res r;
        r.token_kind  = k;
        r.error_code  = e;
        r.start_pos   = p;
        r.token_size  = sz;
        r.line_no     = line_q;
        r.column_no   = c;
        r.int_value   = iv;
        r.char_value  = cv;
        r.last_of_run = 1'b0;
        if (step_out.size() < 2) step_out.push_back(r);
    endtask

    task automatic raise_error(logic [3:0] code, logic [31:0] loc);
        push_token(K_INT, code, loc, 16'd0, tcol, 32'd0, 8'd0);
        halted = 1'b1;
        mode   = S_IDLE;
    endtask

    task automatic open_token(t_mode m);
        mode   = m;
        tstart = pos_q;
        tcol   = col_q;
        tlen   = 16'd1;
    endtask

    task automatic restart_text();
        mode   = S_IDLE;
        pos_q  = '0;
        line_q = '0;
        col_q  = '0;
        halted = 1'b0;
    endtask

    // a byte seen between tokens
    task automatic scan_fresh(logic [7:0] b);
        logic [5:0] k;
        k = op_kind(b);
        mode = S_IDLE;
        if (is_dig(b)) begin
            open_token(S_INT);
            num_q = 32'(b - "0");
            col_q++;
        end else if (is_idc(b)) begin
            open_token(S_WORD);
            letters_q = is_let(b);
            prefix_q  = is_let(b) ? 48'(b) : 48'd0;
            col_q++;
        end else if (b == "\"") begin
            open_token(S_STR);
            col_q++;
        end else if (b == "'") begin
            open_token(S_CHR);
            chr_q = 8'd0;
            col_q++;
        end else if (k != K_INT) begin
            push_token(k, E_NONE, pos_q, 16'd1, col_q, 32'd0, 8'd0);
            col_q++;
        end else if (b == "/") begin
            open_token(S_SLASH);
        end else if (b == "=" || b == "<" || b == ">" || b == "!" || b == "&" || b == "|") begin
            open_token(b == "=" ? S_EQ : b == "<" ? S_LT : b == ">" ? S_GT :
                       b == "!" ? S_BANG : b == "&" ? S_AMP : S_BAR);
            col_q++;
        end else if (b == 8'd0) begin
            push_token(K_END, E_NONE, pos_q, 16'd1, col_q, 32'd0, 8'd0);
            col_q++;
        end else if (b == 8'h0A) begin
            line_q++;
            col_q = '0;
        end else if (b == " ") begin
            col_q++;
        end else begin
            tcol = col_q;
            raise_error(E_UNSUP, pos_q);
        end
    endtask

    // works out the tokens caused by one accepted byte and queues them
    task automatic predict_tokens(logic [7:0] b);
        logic [5:0] k;
        step_out = {};
        if (halted) begin
            if (b == 8'd0) restart_text();
            return;
        end
        case (mode)
            S_INT: begin
                if (is_dig(b)) begin
                    num_q = num_q * 10 + 32'(b - "0");
                    if (tlen != 16'hFFFF) tlen++;
                    col_q++;
                end else if (is_idc(b)) begin
                    raise_error(E_INT_SUFX, pos_q);
                end else begin
                    push_token(K_INT, E_NONE, tstart, tlen, tcol, num_q, 8'd0);
                    scan_fresh(b);
                end
            end
            S_WORD: begin
                if (letters_q && is_let(b)) begin
                    prefix_q = {prefix_q[39:0], b};
                    if (tlen != 16'hFFFF) tlen++;
                    col_q++;
                end else begin
                    k = K_INT;
                    if (letters_q) begin
                        letters_q = 1'b0;
                        k = keyword_of(tlen, prefix_q);
                    end
                    if (k != K_INT) begin
                        push_token(k, E_NONE, tstart, tlen, tcol, 32'd0, 8'd0);
                        scan_fresh(b);
                    end else if (is_idc(b) || is_dig(b)) begin
                        if (tlen != 16'hFFFF) tlen++;
                        col_q++;
                    end else begin
                        push_token(K_IDENT, E_NONE, tstart, tlen, tcol, 32'd0, 8'd0);
                        scan_fresh(b);
                    end
                end
            end
            S_STR: begin
                if (b == "\"") begin
                    col_q++;
                    if (tlen == 16'd1) begin
                        raise_error(E_STR_EMPTY, tstart + 1);
                    end else begin
                        push_token(K_STR, E_NONE, tstart,
                                   tlen == 16'hFFFF ? tlen : tlen + 1, tcol, 32'd0, 8'd0);
                        col_q += 2;
                        mode = S_IDLE;
                    end
                end else if (is_vis(b) || b == 8'h0A || b == 8'h0D || b == 8'h09 || b == " ") begin
                    if (tlen != 16'hFFFF) tlen++;
                    col_q++;
                end else begin
                    raise_error(E_STR_UNTRM, tstart);
                end
            end
            S_CHR: begin
                if (b == "'") begin
                    col_q++;
                    push_token(K_CHR, E_NONE, tstart, tlen + 1, tcol, 32'd0,
                               tlen == 16'd1 ? 8'h27 : chr_q);
                    mode = S_IDLE;
                end else if (is_vis(b)) begin
                    col_q++;
                    tlen++;
                    if (tlen == 16'd2) chr_q = b;
                    if (tlen > 16'd2) raise_error(E_CHR_MULTI, tstart);
                end else begin
                    raise_error(E_CHR_UNTRM, tstart);
                end
            end
            S_SLASH: begin
                if (b == "/") begin
                    mode = S_LINE;
                end else if (b == "#") begin
                    col_q++;
                    mode = S_BLOCK;
                end else begin
                    push_token(K_DIV, E_NONE, tstart + 1, 16'd1, tcol, 32'd0, 8'd0);
                    col_q++;
                    scan_fresh(b);
                end
            end
            S_LINE: if (b == 8'h0A || b == 8'd0) scan_fresh(b);
            S_BLOCK: begin
                if (b == 8'd0) begin
                    scan_fresh(b);
                end else if (b == 8'h0A) begin
                    line_q++;
                    col_q = 16'd1;
                end else begin
                    col_q++;
                    if (b == "#") mode = S_HASH;
                end
            end
            S_HASH: begin
                if (b == 8'd0) begin
                    scan_fresh(b);
                end else begin
                    col_q++;
                    mode = (b == "/") ? S_IDLE : S_BLOCK;
                end
            end
            S_EQ, S_LT, S_GT, S_BANG: begin
                if (b == "=") begin
                    k = mode == S_EQ ? K_EQ : mode == S_LT ? K_LE : mode == S_GT ? K_GE : K_NE;
                    col_q++;
                    push_token(k, E_NONE, tstart, 16'd2, tcol, 32'd0, 8'd0);
                    mode = S_IDLE;
                end else begin
                    k = mode == S_EQ ? K_ASSIGN : mode == S_LT ? K_LT :
                        mode == S_GT ? K_GT : K_NOT;
                    push_token(k, E_NONE, tstart, 16'd1, tcol, 32'd0, 8'd0);
                    scan_fresh(b);
                end
            end
            S_AMP, S_BAR: begin
                if (b == (mode == S_AMP ? "&" : "|")) begin
                    col_q++;
                    push_token(mode == S_AMP ? K_ANDAND : K_OROR, E_NONE, tstart, 16'd2,
                               tcol, 32'd0, 8'd0);
                    mode = S_IDLE;
                end else begin
                    raise_error(mode == S_AMP ? E_AMP : E_BAR, tstart);
                end
            end
            default: scan_fresh(b);
        endcase
        if (b == 8'd0) restart_text();
        else pos_q++;
        if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
        foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sends one source byte, predicting its tokens at the transfer;
    // valid stays high after the transfer until the next byte or a pause
    task automatic send_byte(logic [7:0] b);
        int g;
        g = accepting ? 0 : gap_len();
        if (g > 0) begin
            src_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        src_if.valid       <= 1'b1;
        src_if.source_byte <= b;
        @(posedge i_clk);
        while (!src_if.ready) @(posedge i_clk);
        predict_tokens(b);
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    task automatic drain_tokens();
        src_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    // output side: random stall on ready while rx_random_stall is set, check each transfer
    always @(posedge i_clk) begin
        t_res got;
        t_res exp_tok;
        if (!i_rst_n) begin
            tok_if.ready <= 1'b0;
        end else begin
            if (tok_if.valid && tok_if.ready) begin
                got.token_kind  = tok_if.token_kind;
                got.error_code  = tok_if.error_code;
                got.start_pos   = tok_if.start_pos;
                got.token_size  = tok_if.token_size;
                got.line_no     = tok_if.line_no;
                got.column_no   = tok_if.column_no;
                got.int_value   = tok_if.int_value;
                got.char_value  = tok_if.char_value;
                got.last_of_run = tok_if.last_of_run;
                if (expected_tokens.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected token transfer %p", got);
                end else begin
                    exp_tok = expected_tokens.pop_front();
                    if (got !== exp_tok) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("token mismatch: expected %p, got %p", exp_tok, got);
                    end
                end
            end
            if (rx_random_stall) tok_if.ready <= ($urandom_range(0, 3) != 0);
            else tok_if.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer at either side
    always @(posedge i_clk) begin
        if ((src_if.valid && src_if.ready) || (tok_if.valid && tok_if.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_tokens();
        // keywords, prefix split, operators, literals, comments
        send_text("fn struct if else while return let true false if_x x9 _a\n");
        send_text("+-*%(){}[]:;,. = == < <= > >= ! != && || a/b '' 'q' \"s t\"\n");
        send_text("4294967296 0 //c\n/#a\n##/ #/ 7");
        send_byte(8'd0);
        send_byte(8'd0);
    endtask

    task automatic test_errors();
        send_text("12ab");
        send_byte(8'd0);
        send_text("'ab");
        send_byte(8'd0);
        send_text("'\t");
        send_byte(8'd0);
        send_text("\"\"");
        send_byte(8'd0);
        send_text("\"a\x01");
        send_byte(8'd0);
        send_text("&x");
        send_byte(8'd0);
        send_text("|x");
        send_byte(8'd0);
        send_byte(8'hFF);
        send_byte(8'h0D);
        send_byte(8'd0);
        send_text("'a");
        send_byte(8'd0);
    endtask

    function automatic logic [7:0] pick_char();
        string pool;
        int r;
        pool = "abfilnorstuwe_0123456789 +-*%(){}[]:;,.=<>!&|/#'\"\n";
        r = $urandom_range(0, 99);
        if (r < 4) return 8'($urandom_range(0, 255));
        if (r < 6) return 8'd0;
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic test_random_text();
        string frags[14];
        int n;
        frags = '{"while ", "x_1 ", "return 42;", "\"str ing\"", "'z' ", "a<=b ",
                  "c!=d ", "p&&q ", "r||s ", "/# note #/ ", "// tail\n", "123 ",
                  "fnord ", "\n"};
        n = 0;
        while (n < 440) begin
            if ($urandom_range(0, 3) != 0) begin
                string f;
                f = frags[$urandom_range(0, 13)];
                send_text(f);
                n += f.len();
            end else begin
                send_byte(pick_char());
                n++;
            end
            if (n % 200 < 3) send_byte(8'd0);
        end
        send_byte(8'd0);
        // sender holds off until every token has come out
        drain_tokens();
        rx_random_stall = 1'b0;
        send_text("if 99;");
        send_byte(8'd0);
        accepting = 1'b1;
        send_text("1 2 3 4 5 6 7 8 a+b+c+d");
        send_byte(8'd0);
        accepting = 1'b0;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        src_if.valid       = 1'b0;
        src_if.source_byte = 8'd0;
        tok_if.ready       = 1'b0;
        mismatches         = 0;
        idle_cycles        = 0;
        accepting          = 1'b0;
        rx_random_stall    = 1'b1;
        restart_text();
        tstart = '0; tcol = '0; tlen = '0; num_q = '0;
        prefix_q = '0; letters_q = 1'b0; chr_q = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_tokens();
        test_errors();
        test_random_text();
        drain_tokens();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
